FILE: src/nadf_pkg.sv
// Shared types, constants and helpers for the number to ASCII digit formatter.
// Used by nadf_ctrl, nadf_dp and number_to_ascii_digit_formatter; no dependencies.
package nadf_pkg;

  localparam int VALUE_W = 24;
  localparam int COUNT_W = 3;
  localparam int CHAR_W  = 8;

  // x / 10 == (x * DIV10_MAGIC) >> DIV10_SHIFT, exact for any x below 2**26
  localparam logic [VALUE_W-1:0] DIV10_MAGIC = 24'hCCCCCD;
  localparam int                 DIV10_SHIFT = 27;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_A    = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_DOT  = 8'h2E;

  typedef enum logic [1:0] {
    MODE_DEC  = 2'd0,
    MODE_FIX1 = 2'd1,
    MODE_FIX2 = 2'd2,
    MODE_HEX  = 2'd3
  } fmt_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;       // item produces no characters
    logic conv_done;  // all needed decimal digits are stored
    logic last_pos;   // position counter is at the rightmost character
    logic out_free;   // output register can take a character this cycle
  } dp_sts_t;

  // '0'..'9' then 'A'..'F'
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return ASCII_ZERO + {4'd0, d};
    end else begin
      return ASCII_A + {4'd0, d} - 8'd10;
    end
  endfunction

endpackage

FILE: src/nadf_ctrl.sv
// Controller for the digit formatter: load, convert and emit sequencing.
// Depends on nadf_pkg; drives nadf_dp through command and status structs.
module nadf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  nadf_pkg::dp_sts_t sts,
  output nadf_pkg::dp_cmd_t cmd
);

  nadf_pkg::state_t state;
  nadf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nadf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      nadf_pkg::ST_IDLE: begin
        if (in_valid) state_next = nadf_pkg::ST_CONV;
      end
      nadf_pkg::ST_CONV: begin
        if (sts.skip) begin
          state_next = nadf_pkg::ST_IDLE;
        end else if (sts.conv_done) begin
          state_next = nadf_pkg::ST_EMIT;
        end
      end
      nadf_pkg::ST_EMIT: begin
        if (sts.out_free && sts.last_pos) state_next = nadf_pkg::ST_IDLE;
      end
      default: state_next = nadf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      nadf_pkg::ST_IDLE: begin
        // no item is taken while reset is held
        in_stall = rst;
        cmd.load = in_valid && !rst;
      end
      nadf_pkg::ST_CONV: begin
        cmd.step = !sts.skip && !sts.conv_done;
      end
      nadf_pkg::ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !in_stall)
    else $error("load issued while busy");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.load, cmd.step, cmd.emit}) <= 1)
    else $error("more than one datapath command");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && sts.last_pos) |=> !in_stall)
    else $error("not ready after final character");
`endif

endmodule

FILE: src/nadf_dp.sv
// Datapath for the digit formatter: item registers, divide-by-ten digit
// extraction, digit store, character select and output register.
// Depends on nadf_pkg.
module nadf_dp #(
  parameter int MAX_POSITIONS = 7
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [nadf_pkg::VALUE_W-1:0]   value,
  input  logic [nadf_pkg::COUNT_W-1:0]   digit_count,
  input  logic [1:0]                     mode,
  input  nadf_pkg::dp_cmd_t              cmd,
  output nadf_pkg::dp_sts_t              sts,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [nadf_pkg::CHAR_W-1:0]    character,
  output logic                           last
);

  localparam int DEPTH     = (MAX_POSITIONS < 8) ? MAX_POSITIONS : 7;
  localparam int IW        = $clog2(DEPTH);
  localparam int PROD_W    = 2 * nadf_pkg::VALUE_W;
  localparam int Q_W       = PROD_W - nadf_pkg::DIV10_SHIFT;
  localparam int LIM_FIXED = MAX_POSITIONS;
  localparam int LIM_PLAIN = MAX_POSITIONS - 1;

  logic [nadf_pkg::VALUE_W-1:0] val_r;
  logic [nadf_pkg::VALUE_W-1:0] quot;
  logic [nadf_pkg::COUNT_W-1:0] count_r;
  nadf_pkg::fmt_mode_t          mode_r;
  logic [nadf_pkg::COUNT_W-1:0] step_cnt;
  logic [nadf_pkg::COUNT_W-1:0] pos;
  logic [3:0]                   digits [DEPTH];

  logic [PROD_W-1:0]            prod;
  logic [Q_W-1:0]               q;
  logic [nadf_pkg::VALUE_W-1:0] q10;
  logic [nadf_pkg::VALUE_W-1:0] rem_full;
  logic                         fixed_mode;
  logic [nadf_pkg::COUNT_W-1:0] place;
  logic                         is_dot;
  logic [3:0]                   dec_digit;
  logic [nadf_pkg::VALUE_W-1:0] hex_shift;
  logic [nadf_pkg::CHAR_W-1:0]  char_next;

  // one decimal digit per step, least significant first
  assign prod     = quot * nadf_pkg::DIV10_MAGIC;
  assign q        = prod[PROD_W-1:nadf_pkg::DIV10_SHIFT];
  assign q10      = {q, 3'b000} + {2'b00, q, 1'b0};
  assign rem_full = quot - q10;

  assign fixed_mode = (mode_r == nadf_pkg::MODE_FIX1) || (mode_r == nadf_pkg::MODE_FIX2);

  always_comb begin
    sts.skip = (count_r == '0) ||
               (fixed_mode ? (int'(count_r) > LIM_FIXED) : (int'(count_r) > LIM_PLAIN));
    sts.conv_done = (mode_r == nadf_pkg::MODE_HEX) || (step_cnt == count_r);
    sts.last_pos  = (pos == '0);
    sts.out_free  = !out_valid || !out_stall;
  end

  // digits left of the point sit one decimal place lower than their position
  always_comb begin
    place  = pos;
    is_dot = 1'b0;
    case (mode_r)
      nadf_pkg::MODE_FIX1: begin
        if (pos == 3'd1) begin
          is_dot = 1'b1;
        end else if (pos >= 3'd2) begin
          place = pos - 3'd1;
        end
      end
      nadf_pkg::MODE_FIX2: begin
        if (pos == 3'd2) begin
          is_dot = 1'b1;
        end else if (pos >= 3'd3) begin
          place = pos - 3'd1;
        end
      end
      default: begin
        place = pos;
      end
    endcase
  end

  always_comb begin
    dec_digit = 4'd0;
    if (int'(place) < DEPTH) dec_digit = digits[place[IW-1:0]];
  end

  assign hex_shift = val_r >> {pos, 2'b00};

  always_comb begin
    if (is_dot) begin
      char_next = nadf_pkg::ASCII_DOT;
    end else if (mode_r == nadf_pkg::MODE_HEX) begin
      char_next = nadf_pkg::digit_char(hex_shift[3:0]);
    end else begin
      char_next = nadf_pkg::digit_char(dec_digit);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r    <= value;
      quot     <= value;
      count_r  <= digit_count;
      mode_r   <= nadf_pkg::fmt_mode_t'(mode);
      step_cnt <= '0;
      pos      <= digit_count - 3'd1;
    end else begin
      if (cmd.step) begin
        digits[step_cnt[IW-1:0]] <= rem_full[3:0];
        quot                     <= {{(nadf_pkg::VALUE_W - Q_W){1'b0}}, q};
        step_cnt                 <= step_cnt + 3'd1;
      end
      if (cmd.emit) pos <= pos - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      character <= char_next;
      last      <= sts.last_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("character would overwrite a pending item");

  a_step_decimal: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (mode_r != nadf_pkg::MODE_HEX && step_cnt < count_r))
    else $error("conversion step out of range");

  a_step_depth: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (int'(step_cnt) < DEPTH))
    else $error("digit store overflow");
`endif

endmodule

FILE: src/number_to_ascii_digit_formatter.sv
// Top level of the number to ASCII digit formatter.
// Depends on nadf_pkg, nadf_ctrl and nadf_dp.
//
// Input channel (in_valid/in_stall): one item = value, digit_count, mode.
// Output channel (out_valid/out_stall): digit_count characters per item, most
// significant position first, last set on the final character of a run.
// Modes: plain decimal, one or two fractional digits with a '.', and hex
// ('0'..'9', 'A'..'F'). A count of zero, a count of MAX_POSITIONS or more in
// decimal/hex mode, or above MAX_POSITIONS in the fixed-point modes gives no
// characters.
// Sequence: the item is loaded, then in decimal modes digit_count digits are
// extracted one by one on the shared divide-by-ten unit, then the characters
// leave through the output register.
// in_stall is low only while the block is idle and out of reset; it drops once
// the final character is placed in the output register, so the next item may
// enter while that character still waits. A stalled output holds its character
// and pauses emission. Synchronous reset clears the sequencer and output valid.
module number_to_ascii_digit_formatter #(
  parameter int MAX_POSITIONS = 7
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [nadf_pkg::VALUE_W-1:0] value,
  input  logic [nadf_pkg::COUNT_W-1:0] digit_count,
  input  logic [1:0]                   mode,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [nadf_pkg::CHAR_W-1:0]  character,
  output logic                         last
);

  nadf_pkg::dp_cmd_t cmd;
  nadf_pkg::dp_sts_t sts;

  nadf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  nadf_dp #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .value       (value),
    .digit_count (digit_count),
    .mode        (mode),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .character   (character),
    .last        (last)
  );

endmodule

FILE: test/tb_top.sv
// Testbench for number_to_ascii_digit_formatter: directed and random items,
// with a scoreboard class that predicts every character and checks it.
// Depends on nadf_pkg and the formatter RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int VALUE_W        = nadf_pkg::VALUE_W;
  localparam int COUNT_W        = nadf_pkg::COUNT_W;
  localparam int CHAR_W         = nadf_pkg::CHAR_W;
  localparam int MAX_POS        = 7;
  localparam int RANDOM_ITEMS   = 327;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              lst;
  } expected_char_t;

  // Predicts the characters of each accepted item and checks them in order.
  class char_scoreboard;
    expected_char_t pending_q[$];
    int errors;
    int chars_seen;
    int items_seen;
    int silent_items;

    function logic [CHAR_W-1:0] dec_char(logic [VALUE_W-1:0] v, int place);
      int unsigned q;
      q = 32'(v);
      repeat (place) q = q / 10;
      return nadf_pkg::ASCII_ZERO + CHAR_W'(q % 10);
    endfunction

    function logic [CHAR_W-1:0] char_at(logic [VALUE_W-1:0] v, nadf_pkg::fmt_mode_t m,
                                        int p);
      logic [3:0] nib;
      case (m)
        nadf_pkg::MODE_DEC:  return dec_char(v, p);
        // the point takes a position, so digits left of it shift down a place
        nadf_pkg::MODE_FIX1:
          return (p == 1) ? nadf_pkg::ASCII_DOT : dec_char(v, (p >= 2) ? p - 1 : p);
        nadf_pkg::MODE_FIX2:
          return (p == 2) ? nadf_pkg::ASCII_DOT : dec_char(v, (p >= 3) ? p - 1 : p);
        default: begin
          nib = 4'(v >> (4 * p));
          return (nib < 4'd10) ? nadf_pkg::ASCII_ZERO + CHAR_W'(nib)
                               : nadf_pkg::ASCII_A + CHAR_W'(nib) - 8'd10;
        end
      endcase
    endfunction

    function int note_item(logic [VALUE_W-1:0] v, logic [COUNT_W-1:0] cnt,
                           nadf_pkg::fmt_mode_t m);
      int limit;
      int p;
      expected_char_t e;
      items_seen++;
      limit = (m == nadf_pkg::MODE_FIX1 || m == nadf_pkg::MODE_FIX2) ? MAX_POS : MAX_POS - 1;
      if (cnt == 0 || cnt > limit) begin
        silent_items++;
        return 0;
      end
      for (int k = 0; k < cnt; k++) begin
        p = cnt - 1 - k;
        e.ch = char_at(v, m, p);
        e.lst = (p == 0);
        pending_q.push_back(e);
      end
      return int'(cnt);
    endfunction

    function void check_char(logic [CHAR_W-1:0] ch, logic lst);
      expected_char_t e;
      chars_seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected item: character %h last %b", ch, lst);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (ch !== e.ch) begin
        $error("character mismatch: expected %h, actual %h", e.ch, ch);
        errors++;
      end
      if (lst !== e.lst) begin
        $error("last mismatch: expected %b, actual %b", e.lst, lst);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [VALUE_W-1:0]   value = '0;
  logic [COUNT_W-1:0]   digit_count = '0;
  nadf_pkg::fmt_mode_t  mode = nadf_pkg::MODE_DEC;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CHAR_W-1:0]    character;
  logic                 last;

  logic quiet     = 1'b0;   // no idling on either side
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   idle_cycles = 0;

  char_scoreboard sb = new;

  number_to_ascii_digit_formatter #(.MAX_POSITIONS(MAX_POS)) uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value       (value),
    .digit_count (digit_count),
    .mode        (mode),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .character   (character),
    .last        (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offers one item and holds it until taken; may idle afterwards.
  task automatic send_item(input logic [VALUE_W-1:0] v, input logic [COUNT_W-1:0] cnt,
                           input nadf_pkg::fmt_mode_t m, output int n_chars);
    int gap;
    in_valid    <= 1'b1;
    value       <= v;
    digit_count <= cnt;
    mode        <= m;
    do @(posedge clk); while (in_stall);
    n_chars = sb.note_item(v, cnt, m);
    if (!quiet && $urandom_range(99) < 10) begin
      gap = $urandom_range(6, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver: random stalls, plus one long hold so the block backs up.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 10);
    end
  end

  // Output checking and watchdog on cycles with no handshake at all.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) sb.check_char(character, last);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: %0d characters still expected", sb.pending_q.size());
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int n;
    int k;
    logic [VALUE_W-1:0] v;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // extremes, every mode, zero and oversized counts, short fixed-point runs
    send_item(24'd0,       3'd1, nadf_pkg::MODE_DEC,  n);
    send_item(24'hFFFFFF,  3'd6, nadf_pkg::MODE_DEC,  n);
    send_item(24'hFFFFFF,  3'd6, nadf_pkg::MODE_HEX,  n);
    send_item(24'hABCDEF,  3'd6, nadf_pkg::MODE_HEX,  n);
    send_item(24'h123456,  3'd6, nadf_pkg::MODE_HEX,  n);
    send_item(24'hFFFFFF,  3'd1, nadf_pkg::MODE_HEX,  n);
    send_item(24'd1234,    3'd0, nadf_pkg::MODE_DEC,  n);
    send_item(24'd1234,    3'd0, nadf_pkg::MODE_FIX1, n);
    send_item(24'd1234,    3'd0, nadf_pkg::MODE_FIX2, n);
    send_item(24'd1234,    3'd0, nadf_pkg::MODE_HEX,  n);
    send_item(24'd1234567, 3'd7, nadf_pkg::MODE_DEC,  n);
    send_item(24'hFFFFFF,  3'd7, nadf_pkg::MODE_HEX,  n);
    send_item(24'd1234567, 3'd7, nadf_pkg::MODE_FIX1, n);
    send_item(24'hFFFFFF,  3'd7, nadf_pkg::MODE_FIX2, n);
    send_item(24'd98,      3'd1, nadf_pkg::MODE_FIX1, n);
    send_item(24'd98,      3'd2, nadf_pkg::MODE_FIX1, n);
    send_item(24'd987,     3'd1, nadf_pkg::MODE_FIX2, n);
    send_item(24'd987,     3'd2, nadf_pkg::MODE_FIX2, n);
    send_item(24'd987,     3'd3, nadf_pkg::MODE_FIX2, n);
    send_item(24'd9876543, 3'd5, nadf_pkg::MODE_DEC,  n);
    send_item(24'd555555,  3'd4, nadf_pkg::MODE_FIX1, n);
    send_item(24'd555555,  3'd4, nadf_pkg::MODE_FIX2, n);
    send_item(24'd0,       3'd7, nadf_pkg::MODE_FIX1, n);

    k = 0;
    while (k < RANDOM_ITEMS) begin
      if (k == 60)  hold_req <= 1'b1;
      if (k == 200) quiet <= 1'b1;
      if (k == 260) quiet <= 1'b0;
      case ($urandom_range(9))
        7:       v = VALUE_W'($urandom_range(999));
        8:       v = $urandom_range(1) ? 24'hFFFFFF : 24'd9999999;
        default: v = VALUE_W'($urandom());
      endcase
      send_item(v, COUNT_W'($urandom_range(7)), nadf_pkg::fmt_mode_t'($urandom_range(3)), n);
      k++;
    end
    in_valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items (%0d gave no output), checked %0d characters in all modes,",
             sb.items_seen, sb.silent_items, sb.chars_seen);
    $display("with random stalls on both sides and one long output hold.");
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
